// ===== rtl/conv3x3_wraparound_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// conv3x3_wraparound_filter_top_defines.svh
// Assertion macros shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_WRAPAROUND_FILTER_TOP_DEFINES_SVH
`define CONV3X3_WRAPAROUND_FILTER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define C3WF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3wf same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define C3WF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3wf next-cycle check failed");

`endif

// ===== rtl/c3wf_pkg.sv =====
// ----------------------------------------------------------------------------
// c3wf_pkg
// Types, codes and kernel table of the 3x3 wraparound convolution filter.
// ----------------------------------------------------------------------------
package c3wf_pkg;

    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int PIXEL_W    = 8;
    localparam int SUM_W      = 13;
    localparam int WEIGHT_W   = 4;
    localparam int SEL_W      = 3;
    localparam int TAP_W      = 4;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_KERNELS = 5;

    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS    = 2'd2;

    // Neighbor position along one axis
    localparam logic [1:0] POS_PREV = 2'd0;
    localparam logic [1:0] POS_CUR  = 2'd1;
    localparam logic [1:0] POS_NEXT = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [PIXEL_W-1:0] pixel_value;
    } cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered_value;
        logic                    last_pixel;
        logic                    error_flag;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load_we;
        logic             fetch_start;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             finish;
        logic             err;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
    } dp_status_t;

    // Kernels: sharpen, blur, edge enhance, edge detect, emboss
    localparam logic signed [WEIGHT_W-1:0] KERNELS [NUM_KERNELS][NUM_TAPS] = '{
        '{ 4'sd0, -4'sd1, 4'sd0, -4'sd1, 4'sd5, -4'sd1, 4'sd0, -4'sd1, 4'sd0 },
        '{ 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1 },
        '{ 4'sd0, 4'sd0, 4'sd0, -4'sd1, 4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd0 },
        '{ 4'sd0, 4'sd1, 4'sd0, 4'sd1, -4'sd4, 4'sd1, 4'sd0, 4'sd1, 4'sd0 },
        '{ -4'sd2, -4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd1, 4'sd0, 4'sd1, 4'sd2 }
    };

    // Weight of one tap; unknown selectors give an all-zero kernel
    function automatic logic signed [WEIGHT_W-1:0] kernel_weight(
        input logic [SEL_W-1:0] sel,
        input logic [TAP_W-1:0] tap
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        if ((32'(sel) < NUM_KERNELS) && (32'(tap) < NUM_TAPS))
        begin
            w = KERNELS[sel][tap];
        end
        return w;
    endfunction

    // Row position of a tap in the 3x3 window
    function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] tap);
        logic [1:0] pos;
        unique case (tap)
            4'd0, 4'd1, 4'd2: pos = POS_PREV;
            4'd3, 4'd4, 4'd5: pos = POS_CUR;
            default:          pos = POS_NEXT;
        endcase
        return pos;
    endfunction

    // Column position of a tap in the 3x3 window
    function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] tap);
        logic [1:0] pos;
        unique case (tap)
            4'd0, 4'd3, 4'd6: pos = POS_PREV;
            4'd1, 4'd4, 4'd7: pos = POS_CUR;
            default:          pos = POS_NEXT;
        endcase
        return pos;
    endfunction

endpackage

// ===== rtl/c3wf_ctrl.sv =====
// ----------------------------------------------------------------------------
// c3wf_ctrl
// Sequencer: accepts items, walks the nine taps of a fetch, flags refusals.
// ----------------------------------------------------------------------------
`include "conv3x3_wraparound_filter_top_defines.svh"

module c3wf_ctrl
    import c3wf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       kind,
    input  dp_status_t status,
    output logic       busy,
    output ctl_cmd_t   ctl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_TAP   = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        ctl.load_we = !status.full;
                        ctl.err     = status.full;
                    end
                    else if (status.full)
                    begin
                        ctl.fetch_start = 1'b1;
                        tap_next        = '0;
                        state_next      = S_TAP;
                    end
                    else
                    begin
                        ctl.err = 1'b1;
                    end
                end
            end
            S_TAP:
            begin
                ctl.issue = 1'b1;
                ctl.tap   = tap_reg;
                tap_next  = tap_reg + 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // Hold state and tap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    `C3WF_ASSERT_NEXT(a_fetch_enters_taps, clk, rst_n,
        start && !busy && kind == KIND_FETCH && status.full, state_reg == S_TAP && tap_reg == '0)
    `C3WF_ASSERT_NEXT(a_last_tap_flushes, clk, rst_n,
        state_reg == S_TAP && tap_reg == LAST_TAP, state_reg == S_FLUSH)

endmodule

// ===== rtl/c3wf_datapath.sv =====
// ----------------------------------------------------------------------------
// c3wf_datapath
// Image store, configuration, raster counters, wrapped addressing and MAC.
// ----------------------------------------------------------------------------
`include "conv3x3_wraparound_filter_top_defines.svh"

module c3wf_datapath
    import c3wf_pkg::*;
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             ctl,
    input  logic [PIXEL_W-1:0]   pixel_value,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output dp_status_t           status,
    output result_t              result,
    output logic                 done
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int RW1   = $clog2(MAX_ROWS + 1);
    localparam int CW1   = $clog2(MAX_COLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration
    logic [SEL_W-1:0] filter_select_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;

    // Raster position and load progress
    logic [TW-1:0] load_count_reg, load_count_next;
    logic [RW-1:0] emit_row_reg, emit_row_next;
    logic [CW-1:0] emit_col_reg, emit_col_next;
    logic [AW-1:0] row_base_reg, row_base_next;

    // Window of the fetch in progress
    logic [AW-1:0] prev_base_reg, next_base_reg;
    logic [CW-1:0] col_prev_reg, col_next_reg;

    // Store and accumulate
    logic [PIXEL_W-1:0]         mem [DEPTH];
    logic [PIXEL_W-1:0]         rd_data_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       pending_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    result_t                    result_reg;
    logic                       done_reg;

    logic [RW1-1:0]          rows_eff;
    logic [CW1-1:0]          cols_eff;
    logic [TW-1:0]           total;
    logic [TW-1:0]           cols_t;
    logic [AW-1:0]           prev_base;
    logic [AW-1:0]           next_base;
    logic [CW-1:0]           col_prev;
    logic [CW-1:0]           col_next;
    logic                    row_last;
    logic                    col_last;
    logic [AW-1:0]           tap_base;
    logic [CW-1:0]           tap_col_idx;
    logic [AW-1:0]           tap_addr;
    logic [AW-1:0]           mem_addr;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] d_ext;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;

    // Clamp the size registers into 1..max
    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = RW1'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            rows_eff = RW1'(MAX_ROWS);
        else
            rows_eff = RW1'(rows_reg);

        if (cols_reg == '0)
            cols_eff = CW1'(1);
        else if (32'(cols_reg) > MAX_COLS)
            cols_eff = CW1'(MAX_COLS);
        else
            cols_eff = CW1'(cols_reg);
    end

    assign total       = TW'(rows_eff) * TW'(cols_eff);
    assign cols_t      = TW'(cols_eff);
    assign status.full = (load_count_reg >= total);

    // Wrapped neighbor rows and columns of the current output pixel
    assign row_last = ((RW1'(emit_row_reg) + RW1'(1)) >= rows_eff);
    assign col_last = ((CW1'(emit_col_reg) + CW1'(1)) >= cols_eff);

    always_comb
    begin
        if (emit_row_reg == '0)
            prev_base = AW'(total - cols_t);
        else
            prev_base = AW'(TW'(row_base_reg) - cols_t);

        if (row_last)
            next_base = '0;
        else
            next_base = AW'(TW'(row_base_reg) + cols_t);

        if (emit_col_reg == '0)
            col_prev = CW'(cols_eff - CW1'(1));
        else
            col_prev = emit_col_reg - CW'(1);

        if (col_last)
            col_next = '0;
        else
            col_next = CW'(CW1'(emit_col_reg) + CW1'(1));
    end

    // Address of the tap being read
    always_comb
    begin
        unique case (tap_row(ctl.tap))
            POS_PREV: tap_base = prev_base_reg;
            POS_CUR:  tap_base = row_base_reg;
            default:  tap_base = next_base_reg;
        endcase
        unique case (tap_col(ctl.tap))
            POS_PREV: tap_col_idx = col_prev_reg;
            POS_CUR:  tap_col_idx = emit_col_reg;
            default:  tap_col_idx = col_next_reg;
        endcase
        tap_addr = tap_base + AW'(tap_col_idx);
    end

    assign mem_addr = ctl.load_we ? load_count_reg[AW-1:0] : tap_addr;

    // Weight times pixel for the tap read last cycle
    assign w_ext = SUM_W'(weight_reg);
    assign d_ext = $signed(SUM_W'(rd_data_reg));
    assign prod  = SUM_W'(w_ext * d_ext);
    assign sum   = acc_reg + prod;

    // Advance counters on load, finish and size writes
    always_comb
    begin
        load_count_next = load_count_reg;
        emit_row_next   = emit_row_reg;
        emit_col_next   = emit_col_reg;
        row_base_next   = row_base_reg;

        if (ctl.load_we)
        begin
            load_count_next = load_count_reg + TW'(1);
        end

        if (ctl.finish)
        begin
            if (!col_last)
            begin
                emit_col_next = emit_col_reg + CW'(1);
            end
            else
            begin
                emit_col_next = '0;
                if (!row_last)
                begin
                    emit_row_next = emit_row_reg + RW'(1);
                    row_base_next = next_base_reg;
                end
                else
                begin
                    emit_row_next   = '0;
                    row_base_next   = '0;
                    load_count_next = '0;
                end
            end
        end

        if (wr_en && (wr_index == REG_IMAGE_ROWS || wr_index == REG_IMAGE_COLS))
        begin
            load_count_next = '0;
            emit_row_next   = '0;
            emit_col_next   = '0;
            row_base_next   = '0;
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_select_reg <= '0;
            rows_reg          <= CFG_W'(128);
            cols_reg          <= CFG_W'(128);
            load_count_reg    <= '0;
            emit_row_reg      <= '0;
            emit_col_reg      <= '0;
            row_base_reg      <= '0;
            pending_reg       <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_FILTER_SELECT: filter_select_reg <= wr_data[SEL_W-1:0];
                    REG_IMAGE_ROWS:    rows_reg <= wr_data;
                    REG_IMAGE_COLS:    cols_reg <= wr_data;
                    default:           ;
                endcase
            end
            load_count_reg <= load_count_next;
            emit_row_reg   <= emit_row_next;
            emit_col_reg   <= emit_col_next;
            row_base_reg   <= row_base_next;
            pending_reg    <= ctl.issue;
            done_reg       <= ctl.finish || ctl.err;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.load_we)
        begin
            mem[mem_addr] <= pixel_value;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Latch the window, weights, accumulator and result
    always_ff @(posedge clk)
    begin
        if (ctl.fetch_start)
        begin
            prev_base_reg <= prev_base;
            next_base_reg <= next_base;
            col_prev_reg  <= col_prev;
            col_next_reg  <= col_next;
            acc_reg       <= '0;
        end
        else if (pending_reg)
        begin
            acc_reg <= sum;
        end

        if (ctl.issue)
        begin
            weight_reg <= kernel_weight(filter_select_reg, ctl.tap);
        end

        if (ctl.finish)
        begin
            result_reg.filtered_value <= sum;
            result_reg.last_pixel     <= col_last && row_last;
            result_reg.error_flag     <= 1'b0;
        end
        else if (ctl.err)
        begin
            result_reg.filtered_value <= '0;
            result_reg.last_pixel     <= 1'b0;
            result_reg.error_flag     <= 1'b1;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    `C3WF_ASSERT_NEXT(a_finish_gives_result, clk, rst_n,
        ctl.finish, done_reg && !result_reg.error_flag)
    `C3WF_ASSERT_NEXT(a_refusal_is_clean, clk, rst_n,
        ctl.err, done_reg && result_reg.error_flag && result_reg.filtered_value == '0)
    `C3WF_ASSERT_SAME(a_finish_after_last_tap, clk, rst_n,
        ctl.finish, pending_reg)

endmodule

// ===== rtl/conv3x3_wraparound_filter_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_wraparound_filter_top
// 3x3 convolution of a stored grayscale image with wraparound edges.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on cmd when start is high and busy is low. A load item
//   (kind 0) writes the next pixel in raster order into the image store
//   and returns nothing. A fetch item (kind 1) returns the next
//   filtered output pixel in raster order; last_pixel marks the final one,
//   after which a new image may be loaded.
//   A fetch before the image is full, or a load into a full image, is
//   refused: a transaction with error_flag set follows in the next cycle.
//   Results appear on result for one cycle with done high; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   A fetch holds busy while it makes nine reads of the
//   single-port image store, one per cycle, and then adds the last
//   product; its result is on the outputs in the first cycle with busy
//   low, so a fetch is done before another fetch is taken. Loads and
//   refused items keep busy low and may follow every cycle. A new item
//   may be accepted while a result is on the outputs.
//   Registers (wr_en, wr_index, wr_data): 0 filter select, 1 rows, 2 cols;
//   writing rows or cols restarts loading. Reset clears counters and sets
//   128 x 128 with the sharpen kernel; store contents are undefined.
// ----------------------------------------------------------------------------
module conv3x3_wraparound_filter_top
    import c3wf_pkg::*;
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output result_t              result,
    output logic                 done
);

    ctl_cmd_t   ctl;
    dp_status_t status;

    // Sequencer
    c3wf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (cmd.kind),
        .status (status),
        .busy   (busy),
        .ctl    (ctl)
    );

    // Store, counters and arithmetic
    c3wf_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .pixel_value (cmd.pixel_value),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .status      (status),
        .result      (result),
        .done        (done)
    );

endmodule
